// ===== design/kcnf_pkg.sv =====
// Shared widths, types and saturation helpers for the correlated-noise Kalman filter.
package kcnf_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int PRD_BITS  = 2 * WORD_BITS - FRAC_BITS;
    localparam int SUM_BITS  = PRD_BITS + 2;
    localparam int ACC_BITS  = WORD_BITS + 3;
    localparam int IN_DATA_BITS  = 136;
    localparam int OUT_DATA_BITS = 96;

    localparam logic [5:0] OFS_H = 6'd9;
    localparam logic [5:0] OFS_Q = 6'd18;
    localparam logic [5:0] OFS_R = 6'd27;
    localparam logic [5:0] OFS_C = 6'd36;
    localparam logic [5:0] OFS_X = 6'd45;
    localparam logic [5:0] OFS_P = 6'd48;
    localparam logic [5:0] LAST_ADDR = 6'd56;

    typedef logic signed [WORD_BITS-1:0] t_word;
    typedef logic signed [PRD_BITS-1:0]  t_prd;

    localparam t_word WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam t_word WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

    typedef struct packed {
        logic neg1;
        logic negp;
    } t_mctl;

    function automatic t_word sat_sum(input logic signed [SUM_BITS-1:0] v);
        if (v > SUM_BITS'(WORD_MAX)) begin
            return WORD_MAX;
        end else if (v < SUM_BITS'(WORD_MIN)) begin
            return WORD_MIN;
        end
        return WORD_BITS'(v);
    endfunction

    function automatic t_word sat_acc(input logic signed [ACC_BITS-1:0] v);
        if (v > ACC_BITS'(WORD_MAX)) begin
            return WORD_MAX;
        end else if (v < ACC_BITS'(WORD_MIN)) begin
            return WORD_MIN;
        end
        return WORD_BITS'(v);
    endfunction

endpackage

// ===== design/kcnf_lane.sv =====
// One multiply lane: registered operands, product and rounded product.
module kcnf_lane import kcnf_pkg::*; (
    input  logic  i_clk,
    input  t_word i_a,
    input  t_word i_b,
    output t_prd  o_rnd
);

    t_word r_a;
    t_word r_b;
    logic signed [2*WORD_BITS-1:0] r_p;
    logic signed [2*WORD_BITS-1:0] rsum;
    t_prd r_rnd;

    assign rsum  = r_p + (2*WORD_BITS)'(64'sd1 <<< (FRAC_BITS - 1));
    assign o_rnd = r_rnd;

    always_ff @(posedge i_clk) begin
        r_a   <= i_a;
        r_b   <= i_b;
        r_p   <= r_a * r_b;
        r_rnd <= rsum[2*WORD_BITS-1:FRAC_BITS];
    end

endmodule

// ===== design/kcnf_merge.sv =====
// Merging stage: sums the lane products, saturates, then adds the matrix terms.
module kcnf_merge import kcnf_pkg::*; (
    input  logic  i_clk,
    input  t_mctl i_ctl,
    input  t_prd  i_p0,
    input  t_prd  i_p1,
    input  t_prd  i_p2,
    input  t_word i_add0,
    input  t_word i_add1,
    input  t_word i_add2,
    output t_word o_val
);

    logic signed [SUM_BITS-1:0] sum;
    logic signed [ACC_BITS-1:0] tot;
    t_word r_sum;

    always_comb begin
        sum = SUM_BITS'(i_p0) + (i_ctl.neg1 ? -SUM_BITS'(i_p1) : SUM_BITS'(i_p1))
            + SUM_BITS'(i_p2);
        tot = (i_ctl.negp ? -ACC_BITS'(r_sum) : ACC_BITS'(r_sum))
            + ACC_BITS'(i_add0) + ACC_BITS'(i_add1) + ACC_BITS'(i_add2);
    end

    assign o_val = sat_acc(tot);

    always_ff @(posedge i_clk) begin
        r_sum <= sat_sum(sum);
    end

endmodule

// ===== design/kcnf_div.sv =====
// Bit-serial signed divider for the gain: (num << FRAC_BITS) / den, saturated.
module kcnf_div import kcnf_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_word i_num,
    input  t_word i_den,
    output logic  o_done,
    output t_word o_quo
);

    localparam int NB = WORD_BITS + FRAC_BITS;
    localparam int CB = $clog2(NB);

    logic [WORD_BITS-1:0] r_rem;
    logic [WORD_BITS-1:0] r_d;
    logic [NB-1:0]        r_n;
    logic [NB-1:0]        r_q;
    logic [CB-1:0]        r_cnt;
    logic                 r_sign;
    logic                 r_busy;
    logic                 r_done;
    t_word                r_quo;
    logic [WORD_BITS:0]   trial;
    logic                 ge;
    logic [NB-1:0]        qn;
    logic signed [NB:0]   sq;
    logic [WORD_BITS-1:0] num_mag;
    logic [WORD_BITS-1:0] den_mag;

    always_comb begin
        num_mag = i_num[WORD_BITS-1] ? WORD_BITS'(-(WORD_BITS+1)'(i_num)) : WORD_BITS'(i_num);
        den_mag = i_den[WORD_BITS-1] ? WORD_BITS'(-(WORD_BITS+1)'(i_den)) : WORD_BITS'(i_den);
        trial   = {r_rem, r_n[NB-1]};
        ge      = trial >= {1'b0, r_d};
        qn      = {r_q[NB-2:0], ge};
        sq      = r_sign ? -(NB+1)'({1'b0, qn}) : (NB+1)'({1'b0, qn});
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= '0;
                r_d    <= den_mag;
                r_n    <= {num_mag, {FRAC_BITS{1'b0}}};
                r_q    <= '0;
                r_cnt  <= '0;
                r_sign <= i_num[WORD_BITS-1] ^ i_den[WORD_BITS-1];
            end else if (r_busy) begin
                r_rem <= ge ? WORD_BITS'(trial - {1'b0, r_d}) : trial[WORD_BITS-1:0];
                r_q   <= qn;
                r_n   <= {r_n[NB-2:0], 1'b0};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CB'(NB - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    if (sq > (NB+1)'(WORD_MAX)) begin
                        r_quo <= WORD_MAX;
                    end else if (sq < (NB+1)'(WORD_MIN)) begin
                        r_quo <= WORD_MIN;
                    end else begin
                        r_quo <= WORD_BITS'(sq);
                    end
                end
            end
        end
    end

endmodule

// ===== design/correlated_noise_kalman_3d.sv =====
// Top level: coefficient and state storage, step sequencer, three multiply lanes and merge.
// Load beats are accepted only while the block is idle. A measurement beat runs its steps
// through the three-lane multiply pipeline, the bit-serial divider for the nine gains, the
// multiply pipeline again for the update, and then the output register. A singular innovation
// covariance ends the step after the determinant, with the predicted estimate. One beat is
// worked at a time; a finished result waits in the output register. Synchronous active-low
// reset clears the coefficients, estimate and covariance to zero.
module correlated_noise_kalman_3d import kcnf_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // word_index, word_value, meas_0, meas_1, meas_2, zero fill.
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    // operation.
    input  logic [0:0]               s_axis_tuser,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // est_0, est_1, est_2.
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    // singular.
    output logic [0:0]               m_axis_tuser
);

    typedef enum logic [2:0] {S_IDLE, S_ISSUE, S_DRAIN, S_DIVGO, S_DIVWAIT, S_DONE} t_state;
    typedef enum logic [3:0] {
        ST_XP, ST_XC, ST_PT, ST_PP, ST_HC, ST_HP, ST_S, ST_ADJ,
        ST_DET, ST_PH, ST_MA, ST_K, ST_Y, ST_X, ST_KS, ST_PU
    } t_step;
    typedef enum logic [4:0] {
        SR_ZERO, SR_F, SR_H, SR_Q, SR_R, SR_C, SR_P, SR_T, SR_S, SR_M,
        SR_ADJ, SR_K, SR_HC, SR_X, SR_Y, SR_Z, SR_DET
    } t_src;
    typedef enum logic [1:0] {SH_MAT, SH_VEC, SH_ONE} t_shape;
    typedef struct packed {
        t_src   a;
        logic   ta;
        t_src   b;
        logic   tb;
        t_src   dst;
        t_shape shape;
        logic   negp;
        logic   cof;
        t_src   e0;
        t_src   e1;
        t_src   e2;
        logic   e2t;
    } t_op;
    typedef struct packed {
        logic       valid;
        logic [1:0] i;
        logic [1:0] j;
    } t_ctl;

    t_word r_f [0:8];
    t_word r_h [0:8];
    t_word r_q [0:8];
    t_word r_r [0:8];
    t_word r_c [0:8];
    t_word r_p [0:8];
    t_word r_t [0:8];
    t_word r_s [0:8];
    t_word r_m [0:8];
    t_word r_adj [0:8];
    t_word r_k [0:8];
    t_word r_hc [0:8];
    t_word r_x [0:2];
    t_word r_y [0:2];
    t_word r_z [0:2];
    t_word r_det;

    t_state     r_state;
    t_step      r_step;
    logic [1:0] r_i;
    logic [1:0] r_j;
    logic       r_sing;
    logic       r_ovalid;
    t_word      r_oe0;
    t_word      r_oe1;
    t_word      r_oe2;
    logic       r_osing;
    t_ctl       r_ctl [0:3];

    t_op        op;
    t_ctl       c3;
    logic       in_acc;
    logic       last;
    logic       pipe_busy;
    t_word      lane_a [0:2];
    t_word      lane_b [0:2];
    t_prd       lane_p [0:2];
    t_word      add0;
    t_word      add1;
    t_word      add2;
    t_word      mval;
    t_mctl      mctl;
    logic [3:0] widx;
    logic [3:0] e2idx;
    logic       div_go;
    logic       div_done;
    t_word      div_quo;
    logic [5:0] la;

    function automatic logic [3:0] ix(input logic [1:0] r, input logic [1:0] c);
        return 4'({r, 1'b0}) + 4'(r) + 4'(c);
    endfunction

    function automatic logic [1:0] nx3(input logic [1:0] v);
        return (v == 2'd2) ? 2'd0 : v + 2'd1;
    endfunction

    function automatic t_word rd(input t_src s, input logic [3:0] i);
        case (s)
            SR_F:    return r_f[i];
            SR_H:    return r_h[i];
            SR_Q:    return r_q[i];
            SR_R:    return r_r[i];
            SR_C:    return r_c[i];
            SR_P:    return r_p[i];
            SR_T:    return r_t[i];
            SR_S:    return r_s[i];
            SR_M:    return r_m[i];
            SR_ADJ:  return r_adj[i];
            SR_K:    return r_k[i];
            SR_HC:   return r_hc[i];
            SR_X:    return r_x[i[1:0]];
            SR_Y:    return r_y[i[1:0]];
            SR_Z:    return r_z[i[1:0]];
            default: return '0;
        endcase
    endfunction

    function automatic t_op op_of(input t_step s);
        t_op o;
        o.a = SR_ZERO; o.ta = 1'b0; o.b = SR_ZERO; o.tb = 1'b0; o.dst = SR_ZERO;
        o.shape = SH_MAT; o.negp = 1'b0; o.cof = 1'b0;
        o.e0 = SR_ZERO; o.e1 = SR_ZERO; o.e2 = SR_ZERO; o.e2t = 1'b0;
        case (s)
            ST_XP: begin o.a = SR_F; o.b = SR_X; o.dst = SR_Y; o.shape = SH_VEC; end
            ST_XC: begin o.dst = SR_X; o.shape = SH_VEC; o.e0 = SR_Y; end
            ST_PT: begin o.a = SR_F; o.b = SR_P; o.dst = SR_T; end
            ST_PP: begin o.a = SR_T; o.b = SR_F; o.tb = 1'b1; o.dst = SR_P; o.e0 = SR_Q; end
            ST_HC: begin o.a = SR_H; o.b = SR_C; o.dst = SR_HC; end
            ST_HP: begin o.a = SR_H; o.b = SR_P; o.dst = SR_M; end
            ST_S: begin
                o.a = SR_M; o.b = SR_H; o.tb = 1'b1; o.dst = SR_S;
                o.e0 = SR_R; o.e1 = SR_HC; o.e2 = SR_HC; o.e2t = 1'b1;
            end
            ST_ADJ: begin o.a = SR_S; o.b = SR_S; o.dst = SR_ADJ; o.cof = 1'b1; end
            ST_DET: begin o.a = SR_S; o.b = SR_ADJ; o.dst = SR_DET; o.shape = SH_ONE; end
            ST_PH: begin o.a = SR_P; o.b = SR_H; o.tb = 1'b1; o.dst = SR_M; o.e0 = SR_C; end
            ST_MA: begin o.a = SR_M; o.b = SR_ADJ; o.dst = SR_T; end
            ST_Y: begin
                o.a = SR_H; o.b = SR_X; o.dst = SR_Y; o.shape = SH_VEC;
                o.negp = 1'b1; o.e0 = SR_Z;
            end
            ST_X: begin o.a = SR_K; o.b = SR_Y; o.dst = SR_X; o.shape = SH_VEC; o.e0 = SR_X; end
            ST_KS: begin o.a = SR_K; o.b = SR_S; o.dst = SR_T; end
            ST_PU: begin
                o.a = SR_T; o.b = SR_K; o.tb = 1'b1; o.dst = SR_P; o.negp = 1'b1; o.e0 = SR_P;
            end
            default: begin o.dst = SR_ZERO; end
        endcase
        return o;
    endfunction

    assign op        = op_of(r_step);
    assign c3        = r_ctl[3];
    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign pipe_busy = r_ctl[0].valid || r_ctl[1].valid || r_ctl[2].valid || r_ctl[3].valid;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {r_oe2, r_oe1, r_oe0};
    assign m_axis_tuser  = r_osing;
    assign div_go    = (r_state == S_DIVGO);
    assign la        = s_axis_tdata[5:0];
    assign mctl.neg1 = op.cof;
    assign mctl.negp = op.negp;

    always_comb begin
        last = 1'b0;
        case (op.shape)
            SH_ONE:  last = 1'b1;
            SH_VEC:  last = (r_i == 2'd2);
            default: last = (r_i == 2'd2) && (r_j == 2'd2);
        endcase
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            lane_a[k] = rd(op.a, op.ta ? ix(2'(k), r_i) : ix(r_i, 2'(k)));
            if (op.shape == SH_VEC) begin
                lane_b[k] = rd(op.b, 4'(k));
            end else begin
                lane_b[k] = rd(op.b, op.tb ? ix(r_j, 2'(k)) : ix(2'(k), r_j));
            end
        end
        if (op.cof) begin
            lane_a[0] = rd(SR_S, ix(nx3(r_j), nx3(r_i)));
            lane_b[0] = rd(SR_S, ix(nx3(nx3(r_j)), nx3(nx3(r_i))));
            lane_a[1] = rd(SR_S, ix(nx3(r_j), nx3(nx3(r_i))));
            lane_b[1] = rd(SR_S, ix(nx3(nx3(r_j)), nx3(r_i)));
            lane_a[2] = '0;
            lane_b[2] = '0;
        end
    end

    always_comb begin
        widx  = (op.shape == SH_VEC) ? {2'b00, c3.i} : ix(c3.i, c3.j);
        e2idx = op.e2t ? ix(c3.j, c3.i) : widx;
        add0  = rd(op.e0, widx);
        add1  = rd(op.e1, widx);
        add2  = rd(op.e2, e2idx);
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_lane
            kcnf_lane u_lane (
                .i_clk (i_clk),
                .i_a   (lane_a[g]),
                .i_b   (lane_b[g]),
                .o_rnd (lane_p[g])
            );
        end
    endgenerate

    kcnf_merge u_merge (
        .i_clk  (i_clk),
        .i_ctl  (mctl),
        .i_p0   (lane_p[0]),
        .i_p1   (lane_p[1]),
        .i_p2   (lane_p[2]),
        .i_add0 (add0),
        .i_add1 (add1),
        .i_add2 (add2),
        .o_val  (mval)
    );

    kcnf_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_go),
        .i_num   (r_t[ix(r_i, r_j)]),
        .i_den   (r_det),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < 4; n++) begin
                r_ctl[n] <= '0;
            end
        end else begin
            r_ctl[0] <= '{valid: (r_state == S_ISSUE), i: r_i, j: r_j};
            for (int n = 1; n < 4; n++) begin
                r_ctl[n] <= r_ctl[n-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < 9; n++) begin
                r_f[n] <= '0;
                r_h[n] <= '0;
                r_q[n] <= '0;
                r_r[n] <= '0;
                r_c[n] <= '0;
                r_p[n] <= '0;
            end
            for (int n = 0; n < 3; n++) begin
                r_x[n] <= '0;
            end
        end else if (in_acc && !s_axis_tuser[0]) begin
            if (la < OFS_H) begin
                r_f[la[3:0]] <= s_axis_tdata[37:6];
            end else if (la < OFS_Q) begin
                r_h[4'(la - OFS_H)] <= s_axis_tdata[37:6];
            end else if (la < OFS_R) begin
                r_q[4'(la - OFS_Q)] <= s_axis_tdata[37:6];
            end else if (la < OFS_C) begin
                r_r[4'(la - OFS_R)] <= s_axis_tdata[37:6];
            end else if (la < OFS_X) begin
                r_c[4'(la - OFS_C)] <= s_axis_tdata[37:6];
            end else if (la < OFS_P) begin
                r_x[2'(la - OFS_X)] <= s_axis_tdata[37:6];
            end else if (la <= LAST_ADDR) begin
                r_p[4'(la - OFS_P)] <= s_axis_tdata[37:6];
            end
        end else if (in_acc) begin
            r_z[0] <= s_axis_tdata[69:38];
            r_z[1] <= s_axis_tdata[101:70];
            r_z[2] <= s_axis_tdata[133:102];
        end else if (c3.valid) begin
            case (op.dst)
                SR_P:    r_p[widx] <= mval;
                SR_T:    r_t[widx] <= mval;
                SR_S:    r_s[widx] <= mval;
                SR_M:    r_m[widx] <= mval;
                SR_ADJ:  r_adj[widx] <= mval;
                SR_HC:   r_hc[widx] <= mval;
                SR_X:    r_x[widx[1:0]] <= mval;
                SR_Y:    r_y[widx[1:0]] <= mval;
                SR_DET:  r_det <= mval;
                default: r_det <= r_det;
            endcase
        end else if ((r_state == S_DIVWAIT) && div_done) begin
            r_k[ix(r_i, r_j)] <= div_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_step   <= ST_XP;
            r_i      <= '0;
            r_j      <= '0;
            r_sing   <= 1'b0;
            r_ovalid <= 1'b0;
            r_osing  <= 1'b0;
        end else begin
            if (r_ovalid && m_axis_tready && (r_state != S_DONE)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc && s_axis_tuser[0]) begin
                        r_step  <= ST_XP;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_sing  <= 1'b0;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (last) begin
                        r_state <= S_DRAIN;
                    end else if (op.shape == SH_VEC || r_j == 2'd2) begin
                        r_i <= r_i + 2'd1;
                        r_j <= '0;
                    end else begin
                        r_j <= r_j + 2'd1;
                    end
                end
                S_DRAIN: begin
                    if (!pipe_busy) begin
                        r_i <= '0;
                        r_j <= '0;
                        case (r_step)
                            ST_DET: begin
                                if (r_det == '0) begin
                                    r_sing  <= 1'b1;
                                    r_state <= S_DONE;
                                end else begin
                                    r_step  <= ST_PH;
                                    r_state <= S_ISSUE;
                                end
                            end
                            ST_MA: begin
                                r_step  <= ST_K;
                                r_state <= S_DIVGO;
                            end
                            ST_PU: begin
                                r_state <= S_DONE;
                            end
                            default: begin
                                r_step  <= t_step'(r_step + 4'd1);
                                r_state <= S_ISSUE;
                            end
                        endcase
                    end
                end
                S_DIVGO: begin
                    r_state <= S_DIVWAIT;
                end
                S_DIVWAIT: begin
                    if (div_done) begin
                        if (r_i == 2'd2 && r_j == 2'd2) begin
                            r_i     <= '0;
                            r_j     <= '0;
                            r_step  <= ST_Y;
                            r_state <= S_ISSUE;
                        end else begin
                            if (r_j == 2'd2) begin
                                r_i <= r_i + 2'd1;
                                r_j <= '0;
                            end else begin
                                r_j <= r_j + 2'd1;
                            end
                            r_state <= S_DIVGO;
                        end
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_oe0    <= r_x[0];
                        r_oe1    <= r_x[1];
                        r_oe2    <= r_x[2];
                        r_osing  <= r_sing;
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== tb/tb_correlated_noise_kalman_3d.sv =====
// Self-checking testbench for the correlated-noise three-state Kalman filter stream block.
`timescale 1ns / 1ps

class kalman_scoreboard;
    longint coef [45];
    longint est_x [3];
    longint cov_p [9];
    logic [96:0] pending [$];
    int errors;

    function new();
        foreach (coef[i]) coef[i] = 0;
        foreach (est_x[i]) est_x[i] = 0;
        foreach (cov_p[i]) cov_p[i] = 0;
        errors = 0;
    endfunction

    function longint sat(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function longint rmul(longint a, longint b);
        return (a * b + 64'sd32768) >>> 16;
    endfunction

    function void mat_mul(longint a[9], bit ta, longint b[9], bit tb, output longint o[9]);
        longint acc;
        longint av;
        longint bv;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                acc = 0;
                for (int k = 0; k < 3; k++) begin
                    av = ta ? a[k*3+i] : a[i*3+k];
                    bv = tb ? b[j*3+k] : b[k*3+j];
                    acc += rmul(av, bv);
                end
                o[i*3+j] = sat(acc);
            end
        end
    endfunction

    function void mat_vec(longint a[9], longint v[3], output longint o[3]);
        longint acc;
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int k = 0; k < 3; k++) acc += rmul(a[i*3+k], v[k]);
            o[i] = sat(acc);
        end
    endfunction

    function longint cofactor(longint s[9], int i, int j);
        int r0, r1, c0, c1;
        r0 = (i + 1) % 3;
        r1 = (i + 2) % 3;
        c0 = (j + 1) % 3;
        c1 = (j + 2) % 3;
        return sat(rmul(s[r0*3+c0], s[r1*3+c1]) - rmul(s[r0*3+c1], s[r1*3+c0]));
    endfunction

    function void note_input(logic op, logic [5:0] idx, logic signed [31:0] val,
                             logic signed [31:0] z0, logic signed [31:0] z1,
                             logic signed [31:0] z2);
        longint f[9], h[9], q[9], r[9], c[9];
        longint t[9], hc[9], s[9], m[9], adj[9], kg[9], t2[9];
        longint z[3], y[3], y2[3], xn[3];
        longint acc, det;
        logic sing;
        if (op == 1'b0) begin
            if (idx < 45) coef[idx] = val;
            else if (idx < 48) est_x[idx-45] = val;
            else if (idx <= 56) cov_p[idx-48] = val;
            return;
        end
        z[0] = z0;
        z[1] = z1;
        z[2] = z2;
        for (int i = 0; i < 9; i++) begin
            f[i] = coef[i];
            h[i] = coef[9+i];
            q[i] = coef[18+i];
            r[i] = coef[27+i];
            c[i] = coef[36+i];
        end
        mat_vec(f, est_x, xn);
        est_x = xn;
        mat_mul(f, 0, cov_p, 0, t);
        mat_mul(t, 0, f, 1, t2);
        for (int i = 0; i < 9; i++) cov_p[i] = sat(t2[i] + q[i]);
        mat_mul(h, 0, cov_p, 0, t);
        mat_mul(t, 0, h, 1, t2);
        mat_mul(h, 0, c, 0, hc);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                s[i*3+j] = sat(t2[i*3+j] + r[i*3+j] + hc[i*3+j] + hc[j*3+i]);
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                adj[j*3+i] = cofactor(s, i, j);
        acc = 0;
        for (int j = 0; j < 3; j++) acc += rmul(s[j], adj[j*3]);
        det = sat(acc);
        sing = (det == 0);
        if (!sing) begin
            mat_mul(cov_p, 0, h, 1, m);
            for (int i = 0; i < 9; i++) m[i] = sat(m[i] + c[i]);
            mat_mul(m, 0, adj, 0, t);
            for (int i = 0; i < 9; i++) kg[i] = sat((t[i] * 64'sd65536) / det);
            mat_vec(h, est_x, y);
            for (int i = 0; i < 3; i++) y[i] = sat(z[i] - y[i]);
            mat_vec(kg, y, y2);
            for (int i = 0; i < 3; i++) est_x[i] = sat(est_x[i] + y2[i]);
            mat_mul(kg, 0, s, 0, t);
            mat_mul(t, 0, kg, 1, t2);
            for (int i = 0; i < 9; i++) cov_p[i] = sat(cov_p[i] - t2[i]);
        end
        pending.push_back({sing, est_x[2][31:0], est_x[1][31:0], est_x[0][31:0]});
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endfunction

    function void check_result(logic [95:0] data, logic sing);
        logic [96:0] e;
        if (pending.size() == 0) begin
            report("unexpected beat", data[31:0], '0);
            return;
        end
        e = pending.pop_front();
        if (data[31:0] != e[31:0]) report("est_0", data[31:0], e[31:0]);
        if (data[63:32] != e[63:32]) report("est_1", data[63:32], e[63:32]);
        if (data[95:64] != e[95:64]) report("est_2", data[95:64], e[95:64]);
        if (sing != e[96]) report("singular", sing, e[96]);
    endfunction
endclass

module tb_correlated_noise_kalman_3d import kcnf_pkg::*; ();

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam int ONE = 32'h0001_0000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_BITS-1:0] s_axis_tdata = '0;
    logic [0:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    logic [0:0] m_axis_tuser;

    kalman_scoreboard board;
    longint cycles = 0;
    bit hold_off = 1'b0;

    correlated_noise_kalman_3d uut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tdata, m_axis_tuser[0]);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_off) begin
            m_axis_tready <= 1'b0;
        end else begin
            case ($urandom_range(0, 9))
                0, 1: m_axis_tready <= 1'b0;
                default: m_axis_tready <= 1'b1;
            endcase
        end
    end

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400) : $urandom_range(0, 3);
        if (n > 0) s_axis_tvalid <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic send_beat(logic op, logic [5:0] idx, logic [31:0] val,
                             logic [31:0] z0, logic [31:0] z1, logic [31:0] z2);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {2'b0, z2, z1, z0, val, idx};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        board.note_input(op, idx, val, z0, z1, z2);
        if ($urandom_range(0, 2) != 0) idle_gap();
    endtask

    task automatic load_word(logic [5:0] idx, logic [31:0] val);
        send_beat(OP_LOAD, idx, val, '0, '0, '0);
    endtask

    task automatic step(logic [31:0] z0, logic [31:0] z1, logic [31:0] z2);
        send_beat(OP_STEP, 6'($urandom()), $urandom(), z0, z1, z2);
    endtask

    function automatic logic [31:0] small_word(int mag);
        return $signed($urandom_range(0, 2 * mag)) - mag;
    endfunction

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (board.pending.size() != 0);
    endtask

    // A full set of moderate values for a well-conditioned S; any word may be random.
    task automatic load_model();
        for (int i = 0; i < 57; i++) begin
            logic [31:0] v;
            if (i < 9 || (i >= 9 && i < 18)) v = ((i % 9) % 4 == 0) ? ONE : small_word(ONE / 8);
            else if (i < 36 && ((i - 18) % 9) % 4 == 0) v = ONE / 4 + small_word(ONE / 8);
            else if (i >= 48 && ((i - 48) % 4) == 0) v = ONE + small_word(ONE / 2);
            else if (i >= 45 && i < 48) v = small_word(ONE * 100);
            else v = small_word(ONE / 32);
            if ($urandom_range(0, 15) == 0) v = $urandom();
            load_word(6'(i), v);
        end
    endtask

    initial begin
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        step(32'h7fff_ffff, 32'h8000_0000, 32'h0);
        load_word(6'd63, 32'hffff_ffff);
        load_word(6'd57, 32'h1234_5678);
        for (int i = 0; i < 9; i++)
            load_word(6'(i), (i % 4 == 0) ? 32'h7fff_ffff : 32'h8000_0000);
        load_word(6'd27, ONE);
        load_word(6'd31, ONE);
        load_word(6'd35, ONE);
        load_word(6'd45, 32'h8000_0000);
        step(32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        step(32'h0, 32'h0, 32'h0);
        wait_drained();

        for (int set = 0; set < 8; set++) begin
            load_model();
            for (int n = 0; n < 6; n++) step($urandom(), small_word(ONE * 50), small_word(ONE));
            if (set == 2) begin
                wait_drained();
                repeat (700) @(posedge i_clk);
            end
            if (set == 4) begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (3000) @(posedge i_clk);
                        hold_off = 1'b0;
                    end
                    begin
                        for (int n = 0; n < 5; n++) step($urandom(), $urandom(), $urandom());
                        s_axis_tvalid <= 1'b0;
                        @(posedge i_clk);
                    end
                join
            end
            for (int n = 0; n < 10; n++) begin
                if ($urandom_range(0, 4) == 0)
                    load_word(6'($urandom_range(0, 63)), $urandom());
                else
                    step(small_word(ONE * 20), $urandom(), small_word(ONE * 20));
            end
            wait_drained();
            repeat (700) @(posedge i_clk);
        end

        wait_drained();
        repeat (1000) @(posedge i_clk);
        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
